// ----- rtl/elps_pkg.sv -----
// ----------------------------------------------------------------------------
// elps_pkg
// Shared constants and types for the extra lepton pair selector.
// ----------------------------------------------------------------------------
package elps_pkg;

    localparam int MAX_LEPTONS_DEFAULT = 16;

    localparam int PT_W      = 16;
    localparam int FLAV_W    = 2;
    localparam int Z_W       = 5;
    localparam int OUT_IDX_W = 4;
    localparam int MIN_ID_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = FLAV_W;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [FLAV_W-1:0] FLAVOR_ELE = 2'd0;
    localparam logic [FLAV_W-1:0] FLAVOR_MU  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PASS_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_PT_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBLEAD_PT_MIN = 2'd2;

    localparam logic [Z_W-1:0] Z_NONE = 5'h1F;

    // One kept lepton, without its index (index width follows MAX_LEPTONS).
    typedef struct packed {
        logic            valid;
        logic [PT_W-1:0] pt;
        logic            passes;
    } lepton_rec_t;

    // Handoff flags between neighboring cells.
    typedef struct packed {
        logic present;
        logic push;
    } offer_t;

endpackage

// ----- rtl/elps_cell.sv -----
// ----------------------------------------------------------------------------
// elps_cell
// One slot of the running top-pt row: keep or pass the offered lepton.
// ----------------------------------------------------------------------------
module elps_cell
    import elps_pkg::*;
#(
    parameter int IW = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  offer_t            offer_in,
    input  lepton_rec_t       rec_in,
    input  logic [IW-1:0]     idx_in,
    output offer_t            offer_out,
    output lepton_rec_t       rec_out,
    output logic [IW-1:0]     idx_out,
    output lepton_rec_t       rec_upd,
    output logic [IW-1:0]     idx_upd
);

    lepton_rec_t   slot_reg;
    logic [IW-1:0] idx_reg;
    logic          take;

    // A displaced neighbor is always taken; a fresh candidate needs an empty slot or a strictly higher pt.
    assign take = offer_in.present &&
                  (offer_in.push || !slot_reg.valid || (rec_in.pt > slot_reg.pt));

    always_comb
    begin
        if (take)
        begin
            rec_upd           = rec_in;
            idx_upd           = idx_in;
            offer_out.present = 1'b1;
            offer_out.push    = 1'b1;
            rec_out           = slot_reg;
            idx_out           = idx_reg;
        end
        else
        begin
            rec_upd           = slot_reg;
            idx_upd           = idx_reg;
            offer_out.present = offer_in.present;
            offer_out.push    = 1'b0;
            rec_out           = rec_in;
            idx_out           = idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            idx_reg  <= '0;
        end
        else if (clear)
        begin
            slot_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            slot_reg <= rec_upd;
            idx_reg  <= idx_upd;
        end
    end

endmodule

// ----- rtl/extra_lepton_pair_select.sv -----
// ----------------------------------------------------------------------------
// extra_lepton_pair_select
// Picks the two highest-pt non-Z leptons of an event and checks ID and pt cuts.
// ----------------------------------------------------------------------------
// Leptons of one event stream in on s_axis, one beat each, numbered from 0 in
// arrival order; the beat with tlast closes the event. While s_axis_tready is
// high the block takes one beat every cycle: each beat passes through a row of
// two cells (leader and runner-up) that update as the beat is taken, so events
// may follow each other with no gap. The Z indices come from the first beat of
// the event. A closed event's result passes through the snapshot stage and
// then the output register before it is valid on m_axis. s_axis_tready drops
// only while the snapshot stage and the output register both hold results
// that the sink has not taken. Leptons beyond MAX_LEPTONS are dropped and
// raise the overflow flag of that event's result. Pt is in 1/16 GeV units.
// ----------------------------------------------------------------------------
module extra_lepton_pair_select
    import elps_pkg::*;
#(
    parameter int MAX_LEPTONS = MAX_LEPTONS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data,
    // lepton stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] lep_pt, [16] lep_pass_ele, [17] lep_pass_mu,
    // [22:18] z_index_a, [27:23] z_index_b, [31:28] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] lep_flavor
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   s_axis_tlast,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] lead_index, [7:4] sublead_index
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] pair_found, [1] overflow
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int IDX_W  = (MAX_LEPTONS > 1) ? $clog2(MAX_LEPTONS) : 1;
    localparam int IW     = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
    localparam int CNT_W  = $clog2(MAX_LEPTONS + 1);
    localparam int CMP_W  = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;
    localparam int NCELLS = 2;

    // ------------------------------------------------------------------
    // Configuration registers; the user must write them only while idle, which the block does not enforce.
    // ------------------------------------------------------------------
    logic [MIN_ID_W-1:0] min_pass_id_reg;
    logic [PT_W-1:0]     lead_pt_min_reg;
    logic [PT_W-1:0]     sublead_pt_min_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pass_id_reg    <= '0;
            lead_pt_min_reg    <= '0;
            sublead_pt_min_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_PASS_ID:    min_pass_id_reg    <= cfg_data[MIN_ID_W-1:0];
                CFG_LEAD_PT_MIN:    lead_pt_min_reg    <= cfg_data[PT_W-1:0];
                CFG_SUBLEAD_PT_MIN: sublead_pt_min_reg <= cfg_data[PT_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input beat unpacking
    // ------------------------------------------------------------------
    logic [PT_W-1:0]   in_pt;
    logic              in_pass_ele;
    logic              in_pass_mu;
    logic [Z_W-1:0]    in_za;
    logic [Z_W-1:0]    in_zb;
    logic [FLAV_W-1:0] in_flavor;
    logic              in_beat;

    assign in_pt       = s_axis_tdata[15:0];
    assign in_pass_ele = s_axis_tdata[16];
    assign in_pass_mu  = s_axis_tdata[17];
    assign in_za       = s_axis_tdata[22:18];
    assign in_zb       = s_axis_tdata[27:23];
    assign in_flavor   = s_axis_tuser[FLAV_W-1:0];
    assign in_beat     = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Event bookkeeping: count, overflow, Z indices
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    logic [Z_W-1:0]   zf_reg, zf_next, zf_eff;
    logic [Z_W-1:0]   zs_reg, zs_next, zs_eff;
    logic             first_item;
    logic             in_range;
    logic [IW-1:0]    cur_idx;
    logic             is_z;
    logic             end_beat;

    assign first_item = (count_reg == '0);
    assign in_range   = (count_reg < CNT_W'(MAX_LEPTONS));
    assign zf_eff     = first_item ? in_za : zf_reg;
    assign zs_eff     = first_item ? in_zb : zs_reg;
    assign cur_idx    = IW'(count_reg);
    assign is_z       = (!zf_eff[Z_W-1] && (IW'(zf_eff[Z_W-2:0]) == cur_idx)) ||
                        (!zs_eff[Z_W-1] && (IW'(zs_eff[Z_W-2:0]) == cur_idx));
    assign count_upd  = in_range ? (count_reg + CNT_W'(1)) : count_reg;
    assign ovf_upd    = ovf_reg || !in_range;
    assign end_beat   = in_beat && s_axis_tlast;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        zf_next    = zf_reg;
        zs_next    = zs_reg;
        if (end_beat)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            zf_next    = Z_NONE;
            zs_next    = Z_NONE;
        end
        else if (in_beat)
        begin
            count_next = count_upd;
            ovf_next   = ovf_upd;
            zf_next    = zf_eff;
            zs_next    = zs_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            zf_reg    <= Z_NONE;
            zs_reg    <= Z_NONE;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            zf_reg    <= zf_next;
            zs_reg    <= zs_next;
        end
    end

    // ------------------------------------------------------------------
    // Row of top-pt cells: cell 0 holds the leader, cell 1 the runner-up.
    // A lepton enters cell 0; whatever a cell gives up moves down one.
    // ------------------------------------------------------------------
    offer_t        chain_offer [NCELLS+1];
    lepton_rec_t   chain_rec   [NCELLS+1];
    logic [IW-1:0] chain_idx   [NCELLS+1];
    lepton_rec_t   cell_upd    [NCELLS];
    logic [IW-1:0] cell_idx    [NCELLS];

    assign chain_offer[0].present = in_beat && in_range && !is_z;
    assign chain_offer[0].push    = 1'b0;
    assign chain_rec[0].valid     = 1'b1;
    assign chain_rec[0].pt        = in_pt;
    assign chain_rec[0].passes    = ((in_flavor == FLAVOR_ELE) && in_pass_ele) ||
                                    ((in_flavor == FLAVOR_MU)  && in_pass_mu);
    assign chain_idx[0]           = cur_idx;

    for (genvar c = 0; c < NCELLS; c++)
    begin : g_cell
        elps_cell #(
            .IW (IW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (end_beat),
            .offer_in  (chain_offer[c]),
            .rec_in    (chain_rec[c]),
            .idx_in    (chain_idx[c]),
            .offer_out (chain_offer[c+1]),
            .rec_out   (chain_rec[c+1]),
            .idx_out   (chain_idx[c+1]),
            .rec_upd   (cell_upd[c]),
            .idx_upd   (cell_idx[c])
        );
    end

    // ------------------------------------------------------------------
    // Snapshot stage: hold the closed event's final state.
    // ------------------------------------------------------------------
    logic             snap_valid_reg;
    lepton_rec_t      snap_top_reg, snap_sub_reg;
    logic [IW-1:0]    snap_top_idx_reg, snap_sub_idx_reg;
    logic [CNT_W-1:0] snap_count_reg;
    logic             snap_ovf_reg;
    logic [Z_W-1:0]   snap_zf_reg, snap_zs_reg;
    logic             out_valid_reg;
    logic             out_load;

    assign out_load      = snap_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !snap_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (end_beat)
            snap_valid_reg <= 1'b1;
        else if (out_load)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (end_beat)
        begin
            snap_top_reg     <= cell_upd[0];
            snap_sub_reg     <= cell_upd[1];
            snap_top_idx_reg <= cell_idx[0];
            snap_sub_idx_reg <= cell_idx[1];
            snap_count_reg   <= count_upd;
            snap_ovf_reg     <= ovf_upd;
            snap_zf_reg      <= zf_eff;
            snap_zs_reg      <= zs_eff;
        end
    end

    // ------------------------------------------------------------------
    // Pair check and output register
    // ------------------------------------------------------------------
    logic [MIN_ID_W-1:0] need_id;
    logic [1:0]          npass;
    logic                z_ok;
    logic                found;
    logic [CMP_W-1:0]    cnt_cmp;

    assign need_id = (min_pass_id_reg > MIN_ID_W'(2)) ? MIN_ID_W'(2) : min_pass_id_reg;
    assign npass   = {1'b0, snap_top_reg.passes} + {1'b0, snap_sub_reg.passes};
    assign cnt_cmp = CMP_W'(snap_count_reg);
    assign z_ok    = !snap_zf_reg[Z_W-1] && !snap_zs_reg[Z_W-1] &&
                     (snap_zf_reg != snap_zs_reg) &&
                     (CMP_W'(snap_zf_reg[Z_W-2:0]) < cnt_cmp) &&
                     (CMP_W'(snap_zs_reg[Z_W-2:0]) < cnt_cmp);
    assign found   = z_ok && snap_top_reg.valid && snap_sub_reg.valid &&
                     (npass >= need_id) &&
                     (snap_top_reg.pt >= lead_pt_min_reg) &&
                     (snap_sub_reg.pt >= sublead_pt_min_reg);

    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            // drop the indices when no pair is found
            out_data_reg <= found ? {snap_sub_idx_reg[OUT_IDX_W-1:0],
                                     snap_top_idx_reg[OUT_IDX_W-1:0]} : '0;
            out_user_reg <= {snap_ovf_reg, found};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- tb/pair_select_checker.sv -----
// ----------------------------------------------------------------------------
// pair_select_checker
// Watches the configuration, lepton and result channels of the extra lepton
// pair selector, predicts each event's result and compares it field by field.
// ----------------------------------------------------------------------------
module pair_select_checker
    import elps_pkg::*;
#(
    parameter int MAX_LEPTONS = MAX_LEPTONS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_checked,
    output int                     pairs_found,
    output int                     overflow_events
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                 valid;
        logic [OUT_IDX_W-1:0] idx;
        logic [PT_W-1:0]      pt;
        logic                 passes;
    } kept_lepton_t;

    typedef struct {
        logic                 found;
        logic [OUT_IDX_W-1:0] lead;
        logic [OUT_IDX_W-1:0] sublead;
        logic                 overflow;
    } pair_verdict_t;

    // cut registers
    logic [MIN_ID_W-1:0] need_id;
    logic [PT_W-1:0]     lead_floor;
    logic [PT_W-1:0]     sublead_floor;

    // running state of the open event
    int           seen_count;
    logic         spilled;
    int           z_first;
    int           z_second;
    kept_lepton_t leader;
    kept_lepton_t runner_up;

    pair_verdict_t verdict_q[$];

    task automatic restart_event();
        seen_count = 0;
        spilled    = 1'b0;
        z_first    = -1;
        z_second   = -1;
        leader     = '{1'b0, '0, '0, 1'b0};
        runner_up  = '{1'b0, '0, '0, 1'b0};
    endtask

    task automatic track_lepton(
        input logic [PT_W-1:0]   pt,
        input logic [FLAV_W-1:0] flavor,
        input logic              pass_ele,
        input logic              pass_mu,
        input logic [Z_W-1:0]    z_a,
        input logic [Z_W-1:0]    z_b,
        input logic              last
    );
        logic          passes;
        int            need;
        int            npass;
        pair_verdict_t v;
        // Z indices count only from the opening beat of an event
        if (seen_count == 0) begin
            z_first  = int'($signed(z_a));
            z_second = int'($signed(z_b));
        end
        if (seen_count < MAX_LEPTONS) begin
            passes = (flavor == FLAVOR_ELE && pass_ele) || (flavor == FLAVOR_MU && pass_mu);
            if (seen_count != z_first && seen_count != z_second) begin
                if (!leader.valid || pt > leader.pt) begin
                    runner_up = leader;
                    leader    = '{1'b1, seen_count[OUT_IDX_W-1:0], pt, passes};
                end
                else if (!runner_up.valid || pt > runner_up.pt) begin
                    runner_up = '{1'b1, seen_count[OUT_IDX_W-1:0], pt, passes};
                end
            end
            seen_count++;
        end
        else begin
            spilled = 1'b1;
        end
        if (last) begin
            need    = (need_id > 2) ? 2 : int'(need_id);
            npass   = int'(leader.passes) + int'(runner_up.passes);
            v.found = 1'b1;
            if (z_first < 0 || z_second < 0 || z_first == z_second)
                v.found = 1'b0;
            else if (z_first >= seen_count || z_second >= seen_count)
                v.found = 1'b0;
            if (!leader.valid || !runner_up.valid)
                v.found = 1'b0;
            if (npass < need)
                v.found = 1'b0;
            if (leader.pt < lead_floor || runner_up.pt < sublead_floor)
                v.found = 1'b0;
            v.lead     = v.found ? leader.idx : '0;
            v.sublead  = v.found ? runner_up.idx : '0;
            v.overflow = spilled;
            verdict_q.push_back(v);
            restart_event();
        end
    endtask

    task automatic check_result();
        pair_verdict_t        want;
        logic                 found;
        logic                 overflow;
        logic [OUT_IDX_W-1:0] lead;
        logic [OUT_IDX_W-1:0] sublead;
        found    = m_axis_tuser[0];
        overflow = m_axis_tuser[1];
        lead     = m_axis_tdata[3:0];
        sublead  = m_axis_tdata[7:4];
        if (verdict_q.size() == 0) begin
            $error("result beat with no event pending: tdata %h tuser %h",
                   m_axis_tdata, m_axis_tuser);
            mismatches++;
            return;
        end
        want = verdict_q.pop_front();
        results_checked++;
        if (want.found)
            pairs_found++;
        if (want.overflow)
            overflow_events++;
        if (found !== want.found) begin
            $error("pair_found: expected %0d, got %0d", want.found, found);
            mismatches++;
        end
        if (lead !== want.lead) begin
            $error("lead_index: expected %0d, got %0d", want.lead, lead);
            mismatches++;
        end
        if (sublead !== want.sublead) begin
            $error("sublead_index: expected %0d, got %0d", want.sublead, sublead);
            mismatches++;
        end
        if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            need_id         = '0;
            lead_floor      = '0;
            sublead_floor   = '0;
            restart_event();
            verdict_q.delete();
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
            pairs_found     = 0;
            overflow_events = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_PASS_ID:    need_id       = cfg_data[MIN_ID_W-1:0];
                    CFG_LEAD_PT_MIN:    lead_floor    = cfg_data[PT_W-1:0];
                    CFG_SUBLEAD_PT_MIN: sublead_floor = cfg_data[PT_W-1:0];
                    default: ;
                endcase
            end
            // results leave before the beat of this edge can close an event
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                track_lepton(s_axis_tdata[15:0], s_axis_tuser, s_axis_tdata[16],
                             s_axis_tdata[17], s_axis_tdata[22:18], s_axis_tdata[27:23],
                             s_axis_tlast);
            outstanding = verdict_q.size();
        end
    end

endmodule

// ----- tb/extra_lepton_pair_select_test.sv -----
// ----------------------------------------------------------------------------
// extra_lepton_pair_select_test
// Streams lepton events through the pair selector under changing cuts.
// ----------------------------------------------------------------------------
// A short directed set of events runs first at reset cuts, then several phases
// of random events, each phase after a fresh load of all three cut registers.
// Both the sender and the result sink idle at random; once the sink holds off
// for a long stretch so that the block backs up and stalls its input. The
// checker beside the block predicts every result; this module only drives
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module extra_lepton_pair_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    import elps_pkg::*;

    localparam int CAPACITY         = MAX_LEPTONS_DEFAULT;
    localparam int RANDOM_ITEMS     = 1880;
    localparam int PHASES           = 6;
    localparam int MAX_GAP          = 17;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int PRESSURE_EVENTS  = 40;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 20000;

    // flavor codes beyond electron and muon: neither may ever pass ID
    localparam logic [FLAV_W-1:0] FLAVOR_OTHER = 2'd2;
    localparam logic [FLAV_W-1:0] FLAVOR_SPARE = 2'd3;

    typedef struct packed {
        logic [PT_W-1:0]   pt;
        logic [FLAV_W-1:0] flavor;
        logic              pass_ele;
        logic              pass_mu;
        logic [Z_W-1:0]    z_a;
        logic [Z_W-1:0]    z_b;
        logic              last;
    } lepton_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int mismatches;
    int outstanding;
    int results_checked;
    int pairs_found;
    int overflow_events;

    // stimulus bookkeeping
    lepton_beat_t event_beats[$];
    int           beats_sent   = 0;
    int           items_kept   = 0;
    int           events_sent  = 0;
    bit           sender_gappy = 1'b1;
    bit           sink_gappy   = 1'b1;
    int           hold_requests = 0;
    int           holds_served  = 0;

    // cut settings of the random phases
    logic [MIN_ID_W-1:0] phase_min_id  [PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    logic [PT_W-1:0]     phase_lead_min[PHASES] = '{16'd0, 16'hFFFF, 16'd32768,
                                                    16'd1200, 16'd0, 16'd40000};
    logic [PT_W-1:0]     phase_sub_min [PHASES] = '{16'd0, 16'hFFFF, 16'd16384,
                                                    16'd600, 16'hFFFF, 16'd0};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    extra_lepton_pair_select #(
        .MAX_LEPTONS (CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pair_select_checker #(
        .MAX_LEPTONS (CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .pairs_found     (pairs_found),
        .overflow_events (overflow_events)
    );

    function automatic lepton_beat_t make_beat(
        input logic [PT_W-1:0]   pt,
        input logic [FLAV_W-1:0] flavor,
        input logic              pass_ele,
        input logic              pass_mu,
        input logic [Z_W-1:0]    z_a,
        input logic [Z_W-1:0]    z_b,
        input logic              last
    );
        lepton_beat_t b;
        b.pt       = pt;
        b.flavor   = flavor;
        b.pass_ele = pass_ele;
        b.pass_mu  = pass_mu;
        b.z_a      = z_a;
        b.z_b      = z_b;
        b.last     = last;
        return b;
    endfunction

    // Pt draw: mostly uniform, with the extremes and a tight cluster of
    // repeated values so that ties between leptons happen often.
    function automatic logic [PT_W-1:0] random_pt();
        logic [PT_W-1:0] pt;
        case ($urandom_range(0, 9))
            0:       pt = '0;
            1:       pt = '1;
            2, 3:    pt = PT_W'(4000 + 500 * $urandom_range(0, 3));
            default: pt = PT_W'($urandom());
        endcase
        return pt;
    endfunction

    // Send the queued beats of one event; hold each beat until it is taken.
    task automatic play_event();
        lepton_beat_t b;
        int           gap;
        int           slot;
        slot = 0;
        while (event_beats.size() > 0) begin
            b   = event_beats.pop_front();
            gap = sender_gappy ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom() & 32'h0FFF_FFFF;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {4'b0, b.z_b, b.z_a, b.pass_mu, b.pass_ele, b.pt};
            s_axis_tuser  <= b.flavor;
            s_axis_tlast  <= b.last;
            do @(posedge clk); while (!s_axis_tready);
            @(negedge clk);
            beats_sent++;
            if (slot < CAPACITY)
                items_kept++;
            slot++;
        end
        events_sent++;
    endtask

    // Build one random event. Most events carry a usable Z pair so that the
    // top-two search and the cuts are reached; the rest carry junk Z indices.
    task automatic random_event();
        int             n;
        int             kind;
        int             zmax;
        logic [Z_W-1:0] z_a;
        logic [Z_W-1:0] z_b;
        kind = $urandom_range(0, 99);
        if (kind < 78)
            n = $urandom_range(2, 9);
        else if (kind < 88)
            n = $urandom_range(10, CAPACITY);
        else if (kind < 93)
            n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        else
            n = $urandom_range(1, 6);
        if (kind < 93) begin
            zmax = ((n < CAPACITY) ? n : CAPACITY) - 1;
            z_a  = Z_W'($urandom_range(0, zmax));
            do z_b = Z_W'($urandom_range(0, zmax)); while (z_b == z_a);
        end
        else begin
            z_a = Z_W'($urandom());
            z_b = ($urandom_range(0, 3) == 0) ? z_a : Z_W'($urandom());
        end
        for (int i = 0; i < n; i++) begin
            // Z fields past the opening beat must be ignored: fill with junk
            event_beats.push_back(make_beat(random_pt(), FLAV_W'($urandom_range(0, 3)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            (i == 0) ? z_a : Z_W'($urandom()),
                                            (i == 0) ? z_b : Z_W'($urandom()),
                                            i == n - 1));
        end
        if ($urandom_range(0, 24) == 0)
            sender_gappy = !sender_gappy;
        play_event();
    endtask

    // Drop valid and wait for every pending result, then a few idle cycles.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three cut registers back to back.
    task automatic load_cuts(
        input logic [MIN_ID_W-1:0] min_id,
        input logic [PT_W-1:0]     lead_min,
        input logic [PT_W-1:0]     sublead_min
    );
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    cfg_index <= CFG_MIN_PASS_ID;
                    cfg_data  <= CFG_DAT_W'(min_id);
                end
                1: begin
                    cfg_index <= CFG_LEAD_PT_MIN;
                    cfg_data  <= lead_min;
                end
                default: begin
                    cfg_index <= CFG_SUBLEAD_PT_MIN;
                    cfg_data  <= sublead_min;
                end
            endcase
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result sink: stall a random number of cycles before each beat, and
    // serve a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        while (rst_n !== 1'b1) @(negedge clk);
        forever begin
            stall = sink_gappy ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_requests > holds_served) begin
                stall = SINK_HOLD_CYCLES;
                holds_served++;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
            if ($urandom_range(0, 29) == 0)
                sink_gappy = !sink_gappy;
        end
    end

    // Hard stop for a hung handshake.
    initial begin : watchdog
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int drain_wait;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed events at reset cuts ---------------------------------
        // Z leptons inside the pt range, pair at the pt extremes
        event_beats.push_back(make_beat(16'd500,  FLAVOR_ELE, 1, 0, 5'd2, 5'd0, 0));
        event_beats.push_back(make_beat(16'hFFFF, FLAVOR_ELE, 1, 0, 5'h1F, 5'h1F, 0));
        event_beats.push_back(make_beat(16'd9999, FLAVOR_MU,  0, 1, 5'h10, 5'h0F, 0));
        event_beats.push_back(make_beat(16'd0,    FLAVOR_MU,  0, 1, 5'h0A, 5'h15, 1));
        play_event();
        // equal pt never displaces an earlier lepton
        event_beats.push_back(make_beat(16'd800, FLAVOR_ELE,   1, 1, 5'd0, 5'd1, 0));
        event_beats.push_back(make_beat(16'd900, FLAVOR_MU,    1, 1, 5'd7, 5'd3, 0));
        event_beats.push_back(make_beat(16'd300, FLAVOR_MU,    0, 1, 5'd2, 5'd9, 0));
        event_beats.push_back(make_beat(16'd300, FLAVOR_ELE,   0, 0, 5'd3, 5'd2, 0));
        event_beats.push_back(make_beat(16'd300, FLAVOR_SPARE, 1, 1, 5'd4, 5'd4, 1));
        play_event();
        // only one Z lepton given
        event_beats.push_back(make_beat(16'd100, FLAVOR_ELE, 1, 0, Z_NONE, 5'd1, 0));
        event_beats.push_back(make_beat(16'd200, FLAVOR_MU,  0, 1, 5'd0,   5'd1, 1));
        play_event();
        // both Z indices the same
        event_beats.push_back(make_beat(16'd10, FLAVOR_ELE, 1, 0, 5'd1, 5'd1, 0));
        event_beats.push_back(make_beat(16'd20, FLAVOR_MU,  0, 1, 5'd0, 5'd0, 0));
        event_beats.push_back(make_beat(16'd30, FLAVOR_ELE, 1, 1, 5'd0, 5'd0, 1));
        play_event();
        // Z index past the end of the event
        event_beats.push_back(make_beat(16'd40, FLAVOR_ELE, 1, 0, 5'd0, 5'd5, 0));
        event_beats.push_back(make_beat(16'd50, FLAVOR_MU,  0, 1, 5'd0, 5'd0, 0));
        event_beats.push_back(make_beat(16'd60, FLAVOR_MU,  1, 1, 5'd0, 5'd0, 1));
        play_event();
        // one-lepton event closed on its opening beat
        event_beats.push_back(make_beat(16'd77, FLAVOR_MU, 0, 1, 5'd0, 5'd1, 1));
        play_event();
        // other flavors; a higher pt pushes the leader down, last beat is a Z
        event_beats.push_back(make_beat(16'd70,  FLAVOR_OTHER, 1, 1, 5'd2, 5'd3, 0));
        event_beats.push_back(make_beat(16'd80,  FLAVOR_SPARE, 1, 1, 5'd0, 5'd0, 0));
        event_beats.push_back(make_beat(16'd90,  FLAVOR_ELE,   1, 0, 5'd0, 5'd0, 0));
        event_beats.push_back(make_beat(16'd95,  FLAVOR_MU,    0, 1, 5'd0, 5'd0, 1));
        play_event();

        // --- random phases, each with its own cut setting --------------------
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            load_cuts(phase_min_id[phase], phase_lead_min[phase], phase_sub_min[phase]);
            @(negedge clk);
            if (phase == 2) begin
                // back the block up: long sink hold-off, sender without gaps
                hold_requests++;
                sender_gappy = 1'b0;
                for (int e = 0; e < PRESSURE_EVENTS; e++)
                    random_event();
                sender_gappy = 1'b1;
            end
            while (items_kept < 22 + RANDOM_ITEMS * (phase + 1) / PHASES)
                random_event();
        end

        // --- drain and verdict -----------------------------------------------
        s_axis_tvalid <= 1'b0;
        for (drain_wait = 0; outstanding != 0 && drain_wait < DRAIN_LIMIT; drain_wait++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (outstanding != 0)
            $error("%0d event results never arrived", outstanding);
        $display("Run covered %0d events (%0d lepton beats) over %0d cut settings.",
                 events_sent, beats_sent, PHASES + 1);
        $display("Checked %0d results: %0d pairs found, %0d events over capacity.",
                 results_checked, pairs_found, overflow_events);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
